// ----- design/mse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants for the multi-stack engine
// Command and result payloads, command and status codes, and the
// control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int NUM_STACKS_DEF = 10;
    localparam int MAX_DEPTH_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_DESTROY = 3'd1;
    localparam logic [2:0] CMD_PUSH    = 3'd2;
    localparam logic [2:0] CMD_POP     = 3'd3;
    localparam logic [2:0] CMD_TOP     = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX    = 3'd1;
    localparam logic [2:0] ST_EXISTS       = 3'd2;
    localparam logic [2:0] ST_NOT_CREATED  = 3'd3;
    localparam logic [2:0] ST_FULL         = 3'd4;
    localparam logic [2:0] ST_EMPTY        = 3'd5;
    localparam logic [2:0] ST_BAD_CAPACITY = 3'd6;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  stack_index;
        logic [6:0]  capacity;
        logic [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [31:0] top_value;
        logic [2:0]  status;
        logic        is_empty_flag;
        logic        is_full_flag;
    } rsp_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load_top;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/mse_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ctrl: command sequencer
// Accepts one command at a time, steps the datapath through execution and
// an optional storage read, and raises the result strobe.
// ----------------------------------------------------------------------------
module mse_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output logic                     done,
    output mse_pkg::ctrl_cmd_t       cmd,
    input  wire mse_pkg::dp_stat_t   dstat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cmd.latch    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_top = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (dstat.need_read)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.load_top = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- design/mse_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mse_datapath: stack bookkeeping and shared storage
// Holds per-stack capacity and count registers, the shared word store,
// the command checks and the result register.
// ----------------------------------------------------------------------------
module mse_datapath #(
    parameter int NUM_STACKS = mse_pkg::NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = mse_pkg::MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mse_pkg::req_t        req,
    input  wire mse_pkg::ctrl_cmd_t   cmd,
    output mse_pkg::dp_stat_t         dstat,
    output mse_pkg::rsp_t             rsp
);

    localparam int SIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int WORDS  = NUM_STACKS * MAX_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    mse_pkg::req_t        req_reg;
    mse_pkg::rsp_t        rsp_reg;
    logic [CNT_W-1:0]     cap_reg [NUM_STACKS];
    logic [CNT_W-1:0]     cnt_reg [NUM_STACKS];
    logic [DATA_WIDTH-1:0] mem [WORDS];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic                 idx_ok;
    logic [SIDX_W-1:0]    sidx;
    logic [CNT_W-1:0]     cur_cap;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W-1:0]     cap_next;
    logic [CNT_W-1:0]     cnt_next;
    logic                 made;
    logic                 cap_ok;
    logic                 wr_en;
    logic                 top_ok;
    logic [2:0]           status;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;

    always_comb
    begin
        idx_ok   = ({1'b0, req_reg.stack_index} < 5'(NUM_STACKS));
        sidx     = req_reg.stack_index[SIDX_W-1:0];
        cur_cap  = cap_reg[sidx];
        cur_cnt  = cnt_reg[sidx];
        made     = (cur_cap != '0);
        cap_ok   = (req_reg.capacity != 7'd0) && (req_reg.capacity <= 7'(MAX_DEPTH));
        cap_next = cur_cap;
        cnt_next = cur_cnt;
        wr_en    = 1'b0;
        top_ok   = 1'b0;
        status   = mse_pkg::ST_OK;
        priority if (!idx_ok)
        begin
            status = mse_pkg::ST_BAD_INDEX;
        end
        else if (req_reg.command == mse_pkg::CMD_CREATE)
        begin
            if (made)
            begin
                status = mse_pkg::ST_EXISTS;
            end
            else if (!cap_ok)
            begin
                status = mse_pkg::ST_BAD_CAPACITY;
            end
            else
            begin
                cap_next = CNT_W'(req_reg.capacity);
                cnt_next = '0;
            end
        end
        else if (req_reg.command > mse_pkg::CMD_TOP)
        begin
            status = mse_pkg::ST_OK;
        end
        else if (!made)
        begin
            status = mse_pkg::ST_NOT_CREATED;
        end
        else if (req_reg.command == mse_pkg::CMD_DESTROY)
        begin
            cap_next = '0;
            cnt_next = '0;
        end
        else if (req_reg.command == mse_pkg::CMD_PUSH)
        begin
            if ((cur_cnt >= cur_cap) || (cur_cnt >= CNT_W'(MAX_DEPTH)))
            begin
                status = mse_pkg::ST_FULL;
            end
            else
            begin
                wr_en    = 1'b1;
                cnt_next = cur_cnt + CNT_W'(1);
            end
        end
        else if (cur_cnt == '0)
        begin
            status = mse_pkg::ST_EMPTY;
        end
        else if (req_reg.command == mse_pkg::CMD_POP)
        begin
            cnt_next = cur_cnt - CNT_W'(1);
        end
        else
        begin
            top_ok = 1'b1;
        end
        base    = ADDR_W'(32'(sidx) * 32'(MAX_DEPTH));
        wr_addr = base + ADDR_W'(cur_cnt);
        rd_addr = base + ADDR_W'(cur_cnt - CNT_W'(1));
    end

    assign dstat.need_read = top_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                cap_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.exec && idx_ok)
        begin
            cap_reg[sidx] <= cap_next;
            cnt_reg[sidx] <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= DATA_WIDTH'(req_reg.push_value);
        end
        if (cmd.exec)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg.top_value     <= '0;
            rsp_reg.status        <= status;
            rsp_reg.is_empty_flag <= idx_ok && (cap_next != '0) && (cnt_next == '0);
            rsp_reg.is_full_flag  <= idx_ok && (cap_next != '0) && (cnt_next == cap_next);
        end
        else if (cmd.load_top)
        begin
            rsp_reg.top_value <= 32'(rdata_reg);
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

// ----- design/multi_stack_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stack_engine: bounded stacks in one shared store
// Keeps NUM_STACKS stacks of up to MAX_DEPTH words and executes create,
// destroy, push, pop and read-top commands with status and flags.
// ----------------------------------------------------------------------------
// A command transfer happens at a clock edge where start is high and busy is
// low. The engine works on one command at a time. Its result appears on rsp
// with done high for exactly one cycle, after the execute state, or after a
// further read state for a read top, which waits for the registered read of
// the shared store. The receiver cannot stall the result, and the next
// command may transfer in the same cycle that done is shown; a new command
// is taken only once the result of the last one is shown.
module multi_stack_engine #(
    parameter int NUM_STACKS = mse_pkg::NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = mse_pkg::MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire mse_pkg::req_t  req,
    output logic                done,
    output mse_pkg::rsp_t       rsp
);

    mse_pkg::ctrl_cmd_t cmd;
    mse_pkg::dp_stat_t  dstat;

    mse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .dstat (dstat)
    );

    mse_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .dstat (dstat),
        .rsp   (rsp)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_bad_index_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == mse_pkg::ST_BAD_INDEX) |->
            (!rsp.is_empty_flag && !rsp.is_full_flag))
        else $error("flags set for a bad stack index");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != mse_pkg::ST_OK) |-> (rsp.top_value == 32'd0))
        else $error("data returned with an error status");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.is_empty_flag && rsp.is_full_flag))
        else $error("stack reported both empty and full");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-stack engine
// Commands are sent from a backlog on the start/busy transfer, and each result
// is checked against a cycle-free predictor of the stacks that is updated at
// the moment the command transfers. A short directed run covers every
// command, every error status and the field extremes. It is followed by
// random destroy/create/push/top/pop sequences with some noise, and by
// random send gaps.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS          = mse_pkg::NUM_STACKS_DEF;
    localparam int MD          = mse_pkg::MAX_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TARGET_CMDS = 650;
    localparam int CALM_TAIL   = 100;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct {
        mse_pkg::req_t body;
        int            gap;
    } queued_cmd_t;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    mse_pkg::req_t req   = '0;
    logic          busy;
    logic          done;
    mse_pkg::rsp_t rsp;

    queued_cmd_t   cmd_backlog[$];
    mse_pkg::rsp_t rsp_expected[$];

    logic [6:0]  shadow_cap [NS];
    logic [6:0]  shadow_cnt [NS];
    logic [31:0] shadow_mem [NS*MD];

    int mismatches   = 0;
    int cycles       = 0;
    int idle_left    = 0;
    int queued_total = 0;
    bit took         = 1'b0;
    bit calm         = 1'b0;

    multi_stack_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic mse_pkg::rsp_t stack_apply(mse_pkg::req_t c);
        mse_pkg::rsp_t r;
        int            s;
        int            k;
        int            n;
        r = '0;
        r.status = mse_pkg::ST_OK;
        if (c.stack_index >= NS)
        begin
            r.status = mse_pkg::ST_BAD_INDEX;
        end
        else
        begin
            s = c.stack_index;
            k = shadow_cap[s];
            n = shadow_cnt[s];
            unique case (c.command)
                mse_pkg::CMD_CREATE:
                begin
                    if (k != 0)
                        r.status = mse_pkg::ST_EXISTS;
                    else if (c.capacity < 1 || c.capacity > MD)
                        r.status = mse_pkg::ST_BAD_CAPACITY;
                    else
                    begin
                        shadow_cap[s] = c.capacity;
                        shadow_cnt[s] = '0;
                    end
                end
                mse_pkg::CMD_DESTROY, mse_pkg::CMD_PUSH, mse_pkg::CMD_POP, mse_pkg::CMD_TOP:
                begin
                    if (k == 0)
                        r.status = mse_pkg::ST_NOT_CREATED;
                    else if (c.command == mse_pkg::CMD_DESTROY)
                    begin
                        shadow_cap[s] = '0;
                        shadow_cnt[s] = '0;
                    end
                    else if (c.command == mse_pkg::CMD_PUSH)
                    begin
                        if (n >= k || n >= MD)
                            r.status = mse_pkg::ST_FULL;
                        else
                        begin
                            shadow_mem[s*MD + n] = c.push_value;
                            shadow_cnt[s] = 7'(n + 1);
                        end
                    end
                    else if (n == 0)
                        r.status = mse_pkg::ST_EMPTY;
                    else if (c.command == mse_pkg::CMD_POP)
                        shadow_cnt[s] = 7'(n - 1);
                    else
                        r.top_value = shadow_mem[s*MD + (n - 1) % MD];
                end
                default:
                begin
                end
            endcase
            if (shadow_cap[s] != 0)
            begin
                r.is_empty_flag = (shadow_cnt[s] == 0);
                r.is_full_flag  = (shadow_cnt[s] == shadow_cap[s]);
            end
        end
        return r;
    endfunction

    function automatic void report_mismatch(string what, mse_pkg::rsp_t want,
                                            mse_pkg::rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t mismatch (%s): expected top=%h st=%0d e=%0b f=%0b,",
                      " got top=%h st=%0d e=%0b f=%0b"},
                     $realtime, what, want.top_value, want.status, want.is_empty_flag,
                     want.is_full_flag, got.top_value, got.status, got.is_empty_flag,
                     got.is_full_flag);
    endfunction

    function automatic void check_result(mse_pkg::rsp_t got);
        mse_pkg::rsp_t want;
        string         bad;
        bad = "";
        if (rsp_expected.size() == 0)
        begin
            report_mismatch("result with no command outstanding", '0, got);
        end
        else
        begin
            want = rsp_expected.pop_front();
            if (got.top_value !== want.top_value)
                bad = {bad, " top_value"};
            if (got.status !== want.status)
                bad = {bad, " status"};
            if (got.is_empty_flag !== want.is_empty_flag)
                bad = {bad, " is_empty_flag"};
            if (got.is_full_flag !== want.is_full_flag)
                bad = {bad, " is_full_flag"};
            if (bad != "")
                report_mismatch(bad, want, got);
        end
    endfunction

    function automatic void enqueue(logic [2:0] op, logic [3:0] idx, logic [6:0] size,
                                    logic [31:0] word);
        queued_cmd_t q;
        q.body.command     = op;
        q.body.stack_index = idx;
        q.body.capacity    = size;
        q.body.push_value  = word;
        q.gap = 0;
        if (!calm && queued_total < TARGET_CMDS - CALM_TAIL && $urandom_range(0, 4) == 0)
            q.gap = $urandom_range(1, 7);
        cmd_backlog.push_back(q);
        queued_total++;
    endfunction

    always @(negedge clk)
    begin : driver
        logic        keep;
        queued_cmd_t nxt;
        if (rst_n)
        begin
            keep = start && !took;
            if (!keep)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (cmd_backlog.size() > 0)
                begin
                    if (cmd_backlog[0].gap > 0)
                    begin
                        idle_left = cmd_backlog[0].gap - 1;
                        cmd_backlog[0].gap = 0;
                    end
                    else
                    begin
                        nxt = cmd_backlog.pop_front();
                        req <= nxt.body;
                        keep = 1'b1;
                    end
                end
            end
            start <= keep;
        end
    end

    always @(posedge clk)
    begin : monitor
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
                check_result(rsp);
            took = start && !busy;
            if (took)
                rsp_expected.push_back(stack_apply(req));
        end
    end

    initial
    begin : stimulus
        int         s;
        int         roll;
        int         size;
        int         pushes;
        int         pops;
        logic [3:0] idx;

        foreach (shadow_cap[i])
        begin
            shadow_cap[i] = '0;
            shadow_cnt[i] = '0;
        end
        foreach (shadow_mem[i])
            shadow_mem[i] = '0;

        calm = 1'b1;
        enqueue(mse_pkg::CMD_CREATE, 4'd10, 7'd4, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd15, 7'd127, 32'hFFFF_FFFF);
        enqueue(mse_pkg::CMD_PUSH, 4'd15, 7'd0, 32'h1234_5678);
        enqueue(mse_pkg::CMD_DESTROY, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_PUSH, 4'd0, 7'd0, 32'hA5A5_A5A5);
        enqueue(mse_pkg::CMD_POP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_TOP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd0, 7'(MD + 1), 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd0, 7'd127, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd0, 7'd1, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd0, 7'd5, 32'h0);
        enqueue(mse_pkg::CMD_POP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_TOP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_PUSH, 4'd0, 7'd0, 32'hFFFF_FFFF);
        enqueue(mse_pkg::CMD_PUSH, 4'd0, 7'd0, 32'h0BAD_0BAD);
        enqueue(mse_pkg::CMD_TOP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_POP, 4'd0, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_CREATE, 4'd9, 7'(MD), 32'h0);
        enqueue(mse_pkg::CMD_PUSH, 4'd9, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_TOP, 4'd9, 7'd0, 32'hFFFF_FFFF);
        for (int op = CMD_RSVD_LO; op <= CMD_RSVD_HI; op++)
        begin
            idx = (op == CMD_RSVD_LO) ? 4'd9 : (op == CMD_RSVD_HI) ? 4'd0 : 4'd12;
            enqueue(3'(op), idx, 7'($urandom_range(0, 127)), $urandom);
        end
        enqueue(mse_pkg::CMD_DESTROY, 4'd9, 7'd0, 32'h0);
        enqueue(mse_pkg::CMD_DESTROY, 4'd0, 7'd0, 32'h0);

        while (queued_total < TARGET_CMDS)
        begin
            s = $urandom_range(0, NS - 1);
            calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            if (roll < 2)
            begin
                repeat ($urandom_range(1, 6))
                    enqueue(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                            7'($urandom_range(0, 127)), $urandom);
            end
            else
            begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MD) : $urandom_range(1, 8);
                if ($urandom_range(0, 29) == 0)
                    size = MD;
                if (roll < 8)
                begin
                    enqueue(mse_pkg::CMD_DESTROY, 4'(s), 7'($urandom_range(0, 127)), $urandom);
                    enqueue(mse_pkg::CMD_CREATE, 4'(s), 7'(size), $urandom);
                end
                if ($urandom_range(0, 1) == 0)
                    pushes = size + $urandom_range(0, 1);
                else
                    pushes = $urandom_range(0, size + 1);
                repeat (pushes)
                begin
                    enqueue(mse_pkg::CMD_PUSH, 4'(s), 7'($urandom_range(0, 127)), $urandom);
                    if ($urandom_range(0, 2) == 0)
                        enqueue(mse_pkg::CMD_TOP, 4'(s), 7'($urandom_range(0, 127)),
                                $urandom);
                end
                pops = $urandom_range(0, pushes + 1);
                repeat (pops)
                begin
                    if ($urandom_range(0, 2) == 0)
                        enqueue(mse_pkg::CMD_TOP, 4'(s), 7'($urandom_range(0, 127)),
                                $urandom);
                    enqueue(mse_pkg::CMD_POP, 4'(s), 7'($urandom_range(0, 127)), $urandom);
                end
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || start || idle_left != 0 || rsp_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && rsp_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mse_pkg.sv
design/mse_ctrl.sv
design/mse_datapath.sv
design/multi_stack_engine.sv
tb/sv/tb.sv
